@@ rtl/core/mexp_pkg.sv @@
// ----------------------------------------------------------------------------
// mexp_pkg
// shared types and constants of the modular exponentiation block
// ----------------------------------------------------------------------------
package mexp_pkg;

  // configuration register indexes
  localparam int unsigned REG_MODULUS = 0;

  // modulus after reset
  localparam logic [31:0] MODULUS_RESET = 32'd23;

  // controller to datapath commands
  typedef struct packed {
    logic load;       // capture base and exponent of a new request
    logic red_step;   // one bit of base mod modulus
    logic acc_init;   // power accumulator to one
    logic mul_start;  // clear product, pick multiplier operand
    logic mul_sel;    // 0: square, 1: multiply by reduced base
    logic mul_dbl;    // product doubled mod modulus
    logic mul_add;    // product plus accumulator when multiplier bit set
    logic mul_done;   // product back into the accumulator
    logic exp_shift;  // next exponent bit
    logic finish;     // register the residue
  } mexp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic exp_msb;    // current exponent bit
  } mexp_sts_t;

endpackage

@@ rtl/core/mexp_dp.sv @@
// ----------------------------------------------------------------------------
// mexp_dp
// operand registers and the shared mod-add/subtract unit
// ----------------------------------------------------------------------------
module mexp_dp #(
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                  clk,
  input  logic [WORD_BITS-1:0]  modulus,
  input  logic [WORD_BITS-1:0]  base_value,
  input  logic [WORD_BITS-1:0]  exponent,
  input  mexp_pkg::mexp_cmd_t   cmd,
  output mexp_pkg::mexp_sts_t   sts,
  output logic [WORD_BITS-1:0]  residue
);
  import mexp_pkg::*;

  logic [WORD_BITS-1:0] base_r;
  logic [WORD_BITS-1:0] exp_r;
  logic [WORD_BITS-1:0] red_r;
  logic [WORD_BITS-1:0] acc_r;
  logic [WORD_BITS-1:0] prod_r;
  logic [WORD_BITS-1:0] mult_r;
  logic [WORD_BITS-1:0] residue_r;

  logic [WORD_BITS:0]   sum;
  logic [WORD_BITS:0]   diff;
  logic [WORD_BITS-1:0] red_nxt;
  logic                 mod_small;

  // one conditional subtract serves reduction, doubling and adding
  always_comb begin
    if (cmd.red_step) begin
      sum = {red_r, base_r[WORD_BITS-1]};
    end else if (cmd.mul_dbl) begin
      sum = {1'b0, prod_r} + {1'b0, prod_r};
    end else begin
      sum = {1'b0, prod_r} + {1'b0, acc_r};
    end
    diff = sum - {1'b0, modulus};
    red_nxt = (sum >= {1'b0, modulus}) ? diff[WORD_BITS-1:0] : sum[WORD_BITS-1:0];
  end

  assign mod_small = (modulus[WORD_BITS-1:1] == '0);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      base_r <= base_value;
      exp_r  <= exponent;
      red_r  <= '0;
    end else if (cmd.red_step) begin
      base_r <= {base_r[WORD_BITS-2:0], 1'b0};
      red_r  <= red_nxt;
    end
    if (cmd.exp_shift) begin
      exp_r <= {exp_r[WORD_BITS-2:0], 1'b0};
    end
    if (cmd.acc_init) begin
      acc_r <= WORD_BITS'(1);
    end else if (cmd.mul_done) begin
      acc_r <= prod_r;
    end
    if (cmd.mul_start) begin
      prod_r <= '0;
      mult_r <= cmd.mul_sel ? red_r : acc_r;
    end else if (cmd.mul_dbl) begin
      prod_r <= red_nxt;
    end else if (cmd.mul_add) begin
      if (mult_r[WORD_BITS-1]) begin
        prod_r <= red_nxt;
      end
      mult_r <= {mult_r[WORD_BITS-2:0], 1'b0};
    end
    if (cmd.finish) begin
      residue_r <= mod_small ? '0 : acc_r;
    end
  end

  assign sts.exp_msb = exp_r[WORD_BITS-1];
  assign residue     = residue_r;

endmodule

@@ rtl/core/mexp_ctrl.sv @@
// ----------------------------------------------------------------------------
// mexp_ctrl
// sequencer for reduction, square and multiply passes
// ----------------------------------------------------------------------------
module mexp_ctrl #(
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  output logic                 done_strobe,
  output mexp_pkg::mexp_cmd_t  cmd,
  input  mexp_pkg::mexp_sts_t  sts
);
  import mexp_pkg::*;

  localparam int unsigned CNT_W = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WORD_BITS - 1);

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_REDUCE = 7'b0000010,
    ST_MSTART = 7'b0000100,
    ST_DBL    = 7'b0001000,
    ST_ADD    = 7'b0010000,
    ST_MDONE  = 7'b0100000,
    ST_DONE   = 7'b1000000
  } mexp_state_t;

  mexp_state_t      state_r, state_nxt;
  logic [CNT_W-1:0] bit_cnt_r, bit_cnt_nxt;
  logic [CNT_W-1:0] exp_cnt_r, exp_cnt_nxt;
  logic             mul_sel_r, mul_sel_nxt;
  logic             strobe_r;

  always_comb begin
    state_nxt   = state_r;
    bit_cnt_nxt = bit_cnt_r;
    exp_cnt_nxt = exp_cnt_r;
    mul_sel_nxt = mul_sel_r;
    cmd         = '0;
    cmd.mul_sel = mul_sel_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load    = 1'b1;
          bit_cnt_nxt = '0;
          state_nxt   = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        cmd.red_step = 1'b1;
        bit_cnt_nxt  = bit_cnt_r + 1'b1;
        if (bit_cnt_r == CNT_LAST) begin
          cmd.acc_init = 1'b1;
          exp_cnt_nxt  = '0;
          mul_sel_nxt  = 1'b0;
          state_nxt    = ST_MSTART;
        end
      end
      ST_MSTART: begin
        cmd.mul_start = 1'b1;
        bit_cnt_nxt   = '0;
        state_nxt     = ST_DBL;
      end
      ST_DBL: begin
        cmd.mul_dbl = 1'b1;
        state_nxt   = ST_ADD;
      end
      ST_ADD: begin
        cmd.mul_add = 1'b1;
        bit_cnt_nxt = bit_cnt_r + 1'b1;
        state_nxt   = (bit_cnt_r == CNT_LAST) ? ST_MDONE : ST_DBL;
      end
      ST_MDONE: begin
        cmd.mul_done = 1'b1;
        if (!mul_sel_r && sts.exp_msb) begin
          mul_sel_nxt = 1'b1;
          state_nxt   = ST_MSTART;
        end else begin
          cmd.exp_shift = 1'b1;
          mul_sel_nxt   = 1'b0;
          exp_cnt_nxt   = exp_cnt_r + 1'b1;
          state_nxt     = (exp_cnt_r == CNT_LAST) ? ST_DONE : ST_MSTART;
        end
      end
      ST_DONE: begin
        cmd.finish = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      bit_cnt_r <= '0;
      exp_cnt_r <= '0;
      mul_sel_r <= 1'b0;
      strobe_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      bit_cnt_r <= bit_cnt_nxt;
      exp_cnt_r <= exp_cnt_nxt;
      mul_sel_r <= mul_sel_nxt;
      strobe_r  <= (state_r == ST_DONE);
    end
  end

  assign busy        = (state_r != ST_IDLE);
  assign done_strobe = strobe_r;

endmodule

@@ rtl/core/modular_exponentiation.sv @@
// ----------------------------------------------------------------------------
// modular_exponentiation
// base_value ** exponent mod modulus by left-to-right square and multiply
// ----------------------------------------------------------------------------
//  channel   ports                                   handshake
//  request   start, busy, in_base_value, in_exponent taken when start && !busy
//  result    out_valid, out_residue                  one-cycle strobe, no stall
//  config    psel, penable, pwrite, paddr, pwdata,   apb, pready tied high
//            prdata, pready
//
//  after a request is taken the base is reduced one remainder bit a cycle;
//  each exponent bit then costs one modular square, plus one modular
//  multiply when the bit is set, each made of double and add steps of the
//  shared mod-add unit. the strobe is registered from the done state.
//  reset clears the sequencer and sets modulus to 23.
//  busy stays high for the whole request; the receiver cannot stall.
// ----------------------------------------------------------------------------
module modular_exponentiation #(
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // request
  input  logic                              start,
  output logic                              busy,
  input  logic [WORD_BITS-1:0]              in_base_value,
  input  logic [WORD_BITS-1:0]              in_exponent,
  // result
  output logic                              out_valid,
  output logic [WORD_BITS-1:0]              out_residue,
  // configuration
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [((WORD_BITS > 32) ? 4 : 3)-1:0] paddr,
  input  logic [((WORD_BITS > 32) ? 64 : 32)-1:0] pwdata,
  output logic [((WORD_BITS > 32) ? 64 : 32)-1:0] prdata,
  output logic                              pready
);
  import mexp_pkg::*;

  // register stride is 4 bytes for 32-bit data, 8 for 64-bit
  localparam int unsigned ADDR_W  = (WORD_BITS > 32) ? 4 : 3;
  localparam int unsigned CFG_DW  = (WORD_BITS > 32) ? 64 : 32;
  localparam int unsigned IDX_BIT = ADDR_W - 1;

  logic [WORD_BITS-1:0] modulus_r;
  logic                 cfg_wr;
  logic                 cfg_hit;
  mexp_cmd_t            cmd;
  mexp_sts_t            sts;

  // register index sits above the byte offset bits
  assign cfg_hit = (paddr[IDX_BIT] == 1'(REG_MODULUS));
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;

  // user must rewrite modulus only while no request is in flight; unchecked
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= WORD_BITS'(MODULUS_RESET);
    end else if (cfg_wr && cfg_hit) begin
      modulus_r <= pwdata[WORD_BITS-1:0];
    end
  end

  assign prdata = cfg_hit ? CFG_DW'(modulus_r) : '0;

  // sequencer
  mexp_ctrl #(
    .WORD_BITS (WORD_BITS)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done_strobe (out_valid),
    .cmd         (cmd),
    .sts         (sts)
  );

  // operand registers and mod-add unit
  mexp_dp #(
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk        (clk),
    .modulus    (modulus_r),
    .base_value (in_base_value),
    .exponent   (in_exponent),
    .cmd        (cmd),
    .sts        (sts),
    .residue    (out_residue)
  );

endmodule

@@ rtl/core/mexp_checker.sv @@
// ----------------------------------------------------------------------------
// mexp_checker
// port-level checks on the request and result sequencing
// ----------------------------------------------------------------------------
module mexp_checker #(
  parameter int unsigned WORD_BITS = 32
) (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 start,
  input logic                 busy,
  input logic                 out_valid,
  input logic [WORD_BITS-1:0] out_residue
);

  // a taken request keeps the block busy
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy not raised after a request");

  // the result strobe comes exactly as busy drops
  a_strobe_on_fall: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("busy dropped without a result");

  // no result while a request is in flight
  a_no_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  // a result strobe is always followed by a low out_valid
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  // the residue is well defined when shown
  a_residue_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !$isunknown(out_residue))
    else $error("residue unknown at strobe");

endmodule

bind modular_exponentiation mexp_checker #(
  .WORD_BITS (WORD_BITS)
) u_mexp_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .start       (start),
  .busy        (busy),
  .out_valid   (out_valid),
  .out_residue (out_residue)
);

@@ bench/modular_exponentiation_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// modular_exponentiation_tb
// self-checking bench for the square and multiply exponentiation block
// ----------------------------------------------------------------------------
// requests go in one at a time, with random gaps in between and with start
// sometimes held high while the block is busy. every accepted request gets its
// residue from a local exact-integer model, using the modulus the bench last
// wrote. a monitor checks each result strobe against the oldest expectation.
// the modulus is rewritten over the apb port between phases, only while the
// block is idle, and read back each time.
// ----------------------------------------------------------------------------
module modular_exponentiation_tb;

  import mexp_pkg::*;

  localparam int unsigned WORD_BITS = 32;
  localparam int unsigned ADDR_BITS = 3;
  // first index past the register map, writes there must be dropped
  localparam int unsigned UNMAPPED_INDEX = REG_MODULUS + 1;
  // no accepted request, result or register access for this long ends the run
  localparam int unsigned STALL_LIMIT = 20000;
  // cycles to let pass after the last result before a register write or the end
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned RANDOM_PER_SETTING = 24;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [WORD_BITS-1:0] in_base_value = '0;
  logic [WORD_BITS-1:0] in_exponent = '0;
  logic                 out_valid;
  logic [WORD_BITS-1:0] out_residue;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [ADDR_BITS-1:0] paddr = '0;
  logic [31:0]          pwdata = '0;
  logic [31:0]          prdata;
  logic                 pready;

  // bench copy of the modulus register
  logic [WORD_BITS-1:0] modulus_copy = MODULUS_RESET;
  // residues still owed by the block, oldest first
  logic [WORD_BITS-1:0] residue_q[$];
  int unsigned          mismatch_count = 0;
  int unsigned          stall_cycles = 0;

  modular_exponentiation #(
    .WORD_BITS(WORD_BITS)
  ) DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_base_value(in_base_value),
    .in_exponent  (in_exponent),
    .out_valid    (out_valid),
    .out_residue  (out_residue),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #1 clk = ~clk;

  // exact base ** power mod modulus, left to right over the exponent bits
  // (products of two values below 2^32 fit in 64 bits, so no serial steps)
  function automatic logic [WORD_BITS-1:0] modpow_residue(
    input logic [WORD_BITS-1:0] base,
    input logic [WORD_BITS-1:0] power,
    input logic [WORD_BITS-1:0] modulus
  );
    logic [63:0] m;
    logic [63:0] b;
    logic [63:0] acc;
    // moduli zero and one give zero
    if (modulus <= 1) return '0;
    m = modulus;
    b = base % m;
    acc = 64'd1;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      acc = (acc * acc) % m;
      if (power[i]) acc = (acc * b) % m;
    end
    return acc[WORD_BITS-1:0];
  endfunction

  task automatic report_mismatch(input string what, input logic [WORD_BITS-1:0] expected,
                                 input logic [WORD_BITS-1:0] actual);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t: mismatch on %s: expected 0x%08h, got 0x%08h", $realtime, what,
               expected, actual);
  endtask

  // mostly back to back or short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 4);
    if (r < 97) return $urandom_range(5, 30);
    return $urandom_range(100, 400);
  endfunction

  // result monitor: the strobe cannot be held off, so it is checked every cycle
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (residue_q.size() == 0) begin
        report_mismatch("unexpected result", '0, out_residue);
      end else begin
        logic [WORD_BITS-1:0] want;
        want = residue_q.pop_front();
        if (out_residue !== want) report_mismatch("residue", want, out_residue);
      end
    end
  end

  // watchdog on cycles with no traffic at all
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (psel && penable && pready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: no traffic for %0d cycles, %0d results outstanding",
               STALL_LIMIT, residue_q.size());
      $display("RESULT: ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // one request: hold start until the block takes it, then maybe idle a while
  task automatic send_request(input logic [WORD_BITS-1:0] base,
                              input logic [WORD_BITS-1:0] power);
    int unsigned gap;
    start         <= 1'b1;
    in_base_value <= base;
    in_exponent   <= power;
    do @(posedge clk); while (busy);
    residue_q.push_back(modpow_residue(base, power, modulus_copy));
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // drop start, wait for every owed result and for the sequencer to go quiet
  task automatic wait_idle();
    start <= 1'b0;
    while (residue_q.size() != 0) @(posedge clk);
    while (busy) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // apb write: setup cycle, access cycle, then the bus goes idle
  task automatic write_register(input int unsigned index, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_BITS'(index * 4);
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (index == REG_MODULUS) modulus_copy = value;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // apb read of the modulus, compared against the bench copy
  task automatic check_modulus_readback();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_BITS'(REG_MODULUS * 4);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== modulus_copy) report_mismatch("modulus readback", modulus_copy, prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_modulus(input logic [WORD_BITS-1:0] value);
    wait_idle();
    write_register(REG_MODULUS, value);
    check_modulus_readback();
  endtask

  // reset modulus of 23 with the textbook key exchange numbers
  task automatic test_reset_modulus();
    check_modulus_readback();
    send_request(32'd5, 32'd6);
    send_request(32'd5, 32'd15);
    send_request(32'd8, 32'd15);
    send_request(32'd19, 32'd0);
  endtask

  // field extremes under the largest modulus
  task automatic test_field_extremes();
    set_modulus('1);
    send_request('0, '0);
    send_request('0, '1);
    send_request('1, '1);
    send_request(32'hFFFF_FFFE, '1);
    send_request(32'd1, '1);
    send_request('1, 32'd1);
    send_request(32'h8000_0000, 32'h8000_0000);
    send_request(32'hAAAA_AAAA, 32'h5555_5555);
  endtask

  // smallest valid modulus, the degenerate moduli, ignored write, reduced base
  task automatic test_special_moduli();
    set_modulus(32'd2);
    send_request(32'd3, 32'd5);
    send_request('1, '0);
    // modulus one, every residue zero
    set_modulus(32'd1);
    send_request(32'd7, 32'd9);
    send_request('0, '0);
    // modulus zero has no meaning, residue zero
    set_modulus(32'd0);
    send_request(32'd5, 32'd3);
    send_request('0, '0);
    // a write past the register map must leave the modulus alone
    wait_idle();
    write_register(UNMAPPED_INDEX, 32'd17);
    check_modulus_readback();
    send_request(32'd5, 32'd3);
    // base at or above the modulus gets reduced first
    set_modulus(MODULUS_RESET);
    send_request(32'd100, 32'd7);
    send_request(32'd23, 32'd5);
  endtask

  task automatic random_requests(input int unsigned count);
    logic [WORD_BITS-1:0] base;
    logic [WORD_BITS-1:0] power;
    int unsigned          kind;
    repeat (count) begin
      kind = $urandom_range(0, 9);
      base = (kind < 7) ? $urandom() : (kind < 9) ? $urandom_range(0, 15)
                                                  : modulus_copy + $urandom_range(0, 3);
      kind = $urandom_range(0, 9);
      power = (kind < 7) ? $urandom() : (kind < 9) ? $urandom_range(0, 20)
                                                   : ~($urandom() & $urandom());
      send_request(base, power);
    end
  endtask

  // random requests across a spread of moduli
  task automatic test_random_moduli();
    set_modulus(32'hFFFF_FFFB);
    random_requests(RANDOM_PER_SETTING);
    set_modulus($urandom_range(2, 1000));
    random_requests(RANDOM_PER_SETTING);
    set_modulus(32'h8000_0000);
    random_requests(RANDOM_PER_SETTING);
    set_modulus($urandom() | 32'h8000_0000);
    random_requests(RANDOM_PER_SETTING);
    set_modulus($urandom_range(2, 32'hFFFF_FFFF));
    random_requests(RANDOM_PER_SETTING);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_modulus();
    test_field_extremes();
    test_special_moduli();
    test_random_moduli();
    wait_idle();
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
